FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock edge, off while reset is asserted.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// The vector has exactly one bit set whenever the condition holds.
`define ASSERT_ONEHOT_WHEN(lbl, clk, rst_n, cond, vec, msg) \
  `ASSERT_PROP(lbl, clk, rst_n, (cond) |-> $onehot(vec), msg)

`endif

FILE: hw/rtl/sstd_pkg.sv
package sstd_pkg;

  typedef enum logic [1:0] {
    FuncText  = 2'd0,
    FuncDec   = 2'd1,
    FuncScan  = 2'd2,
    FuncClear = 2'd3
  } func_e;

  typedef struct packed {
    func_e      func;
    logic [7:0] char_code;
    logic       first;
    logic [2:0] position;
  } item_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] pat;
  } font_t;

  localparam logic [7:0] DotBit   = 8'h80;
  localparam logic [7:0] CharNul  = 8'h00;
  localparam logic [7:0] CharDot  = 8'h2e;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;
  localparam logic [7:0] Blank    = 8'h00;

  function automatic logic [7:0] digit_font(input logic [3:0] d);
    logic [7:0] p;
    unique case (d)
      4'd0:    p = 8'h3f;
      4'd1:    p = 8'h06;
      4'd2:    p = 8'h5b;
      4'd3:    p = 8'h4f;
      4'd4:    p = 8'h66;
      4'd5:    p = 8'h6d;
      4'd6:    p = 8'h7d;
      4'd7:    p = 8'h07;
      4'd8:    p = 8'h7f;
      4'd9:    p = 8'h6f;
      default: p = Blank;
    endcase
    return p;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CharZero) && (c <= CharNine);
  endfunction

  // Text font; a miss leaves the digit as it was.
  function automatic font_t font_lookup(input logic [7:0] c);
    font_t f;
    f.hit = 1'b1;
    f.pat = Blank;
    unique case (c) inside
      [8'h30:8'h39]: f.pat = digit_font(c[3:0]);
      8'h41, 8'h61:  f.pat = 8'h77;
      8'h42, 8'h62:  f.pat = 8'h7c;
      8'h43, 8'h63:  f.pat = 8'h39;
      8'h44, 8'h64:  f.pat = 8'h5e;
      8'h45, 8'h65:  f.pat = 8'h79;
      8'h46, 8'h66:  f.pat = 8'h71;
      8'h4f:         f.pat = 8'h3f;
      8'h6f:         f.pat = 8'h5c;
      8'h52, 8'h72:  f.pat = 8'h50;
      8'h50, 8'h70:  f.pat = 8'h73;
      8'h4e, 8'h6e:  f.pat = 8'h37;
      8'h2d:         f.pat = 8'h40;
      8'h20, 8'h09:  f.pat = Blank;
      8'h4c:         f.pat = 8'h38;
      8'h6c:         f.pat = 8'h30;
      8'h56:         f.pat = 8'h3e;
      8'h48:         f.pat = 8'h76;
      default:       f.hit = 1'b0;
    endcase
    return f;
  endfunction

endpackage

FILE: hw/rtl/sstd_digit_buf.sv
module sstd_digit_buf #(
  parameter int unsigned DIGITS = 6,
  localparam int unsigned ScanW = (DIGITS > 1) ? $clog2(DIGITS) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 upd_en_i,
  input  sstd_pkg::item_t      item_i,
  input  logic [ScanW-1:0]     scan_idx_i,
  output logic [7:0]           scan_pat_o
);
  import sstd_pkg::*;

  localparam int unsigned WposW = $clog2(DIGITS + 1);
  localparam logic [WposW-1:0] WposEnd = WposW'(DIGITS);

  logic [7:0]       buf_q [DIGITS];
  logic [7:0]       buf_d [DIGITS];
  logic [WposW-1:0] wpos_q, wpos_d;
  logic [WposW-1:0] wpos_eff;
  font_t            font;
  logic             dec_ok;

  assign wpos_eff = item_i.first ? '0 : wpos_q;
  assign font     = font_lookup(item_i.char_code);
  assign dec_ok   = (32'(item_i.position) < DIGITS) && is_digit(item_i.char_code);

  always_comb begin
    wpos_d = wpos_q;
    for (int k = 0; k < DIGITS; k++) begin
      buf_d[k] = buf_q[k];
    end
    unique case (item_i.func)
      FuncText: begin
        wpos_d = wpos_eff;
        if (wpos_eff < WposEnd) begin
          if (item_i.char_code == CharNul) begin
            // Terminator blanks the rest of the line and locks out further text until a restart.
            for (int k = 0; k < DIGITS; k++) begin
              if (WposW'(k) >= wpos_eff) begin
                buf_d[k] = Blank;
              end
            end
            wpos_d = WposEnd;
          end else if (item_i.char_code == CharDot) begin
            // The dot belongs to the digit just written; none exists at the start.
            for (int k = 0; k < DIGITS; k++) begin
              if (WposW'(k + 1) == wpos_eff) begin
                buf_d[k] = buf_q[k] | DotBit;
              end
            end
          end else begin
            for (int k = 0; k < DIGITS; k++) begin
              if (font.hit && (WposW'(k) == wpos_eff)) begin
                buf_d[k] = font.pat;
              end
            end
            wpos_d = wpos_eff + WposW'(1);
          end
        end
      end
      FuncDec: begin
        for (int k = 0; k < DIGITS; k++) begin
          if (dec_ok && (32'(item_i.position) == k)) begin
            buf_d[k] = digit_font(item_i.char_code[3:0]);
          end
        end
      end
      FuncClear: begin
        for (int k = 0; k < DIGITS; k++) begin
          buf_d[k] = Blank;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q <= '0;
      for (int k = 0; k < DIGITS; k++) begin
        buf_q[k] <= Blank;
      end
    end else if (upd_en_i) begin
      wpos_q <= wpos_d;
      for (int k = 0; k < DIGITS; k++) begin
        buf_q[k] <= buf_d[k];
      end
    end
  end

  assign scan_pat_o = buf_q[scan_idx_i];

endmodule

FILE: hw/rtl/seven_segment_text_display_top.sv
// Channel | Handshake                | Payload
// --------+--------------------------+-------------------------------------------
// in      | in_valid_i / in_ready_o  | func_i, char_code_i, first_i, position_i
// out     | out_valid_o / out_ready_i| segments_n_o, digit_enable_o
//
// Each accepted item waits in the input register while the update logic works
// on it, and retires when it advances. A scan tick's result is then captured
// in the output register, where it is presented until it is taken.
// One item is taken per cycle; the only stall is a scan tick that meets an
// output register whose result is not being taken in that cycle.
// Reset blanks all digits and returns the write position and scan to digit 0.
`include "assert_macros.svh"

module seven_segment_text_display_top #(
  parameter int unsigned DIGITS = 6,
  localparam int unsigned ScanW = (DIGITS > 1) ? $clog2(DIGITS) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        func_i,
  input  logic [7:0]        char_code_i,
  input  logic              first_i,
  input  logic [2:0]        position_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        segments_n_o,
  output logic [DIGITS-1:0] digit_enable_o
);
  import sstd_pkg::*;

  localparam logic [ScanW-1:0] ScanLast = ScanW'(DIGITS - 1);

  // Input register: holds the item being executed this cycle.
  logic             in_vld_q, in_vld_d;
  item_t            item_q;
  logic             in_acc;
  logic             is_scan;
  logic             adv;
  logic             scan_stall;

  // Scan state and result register.
  logic [ScanW-1:0]  scan_idx_q, scan_idx_d;
  logic [7:0]        scan_pat;
  logic              out_vld_q, out_vld_d;
  logic [7:0]        seg_q;
  logic [DIGITS-1:0] en_q;

  assign is_scan = (item_q.func == FuncScan);

  // The held item retires unless it is a scan tick blocked by an untaken result.
  assign adv        = in_vld_q && (!is_scan || !out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;
  assign in_acc     = in_valid_i && in_ready_o;
  assign scan_stall = in_vld_q && is_scan && out_vld_q && !out_ready_i;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_acc) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.func      <= func_e'(func_i);
      item_q.char_code <= char_code_i;
      item_q.first     <= first_i;
      item_q.position  <= position_i;
    end
  end

  // The digit store applies text, decimal and clear items and serves the scan read.
  sstd_digit_buf #(
    .DIGITS(DIGITS)
  ) u_digit_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .upd_en_i  (adv),
    .item_i    (item_q),
    .scan_idx_i(scan_idx_q),
    .scan_pat_o(scan_pat)
  );

  // The scan walks the digits in order and wraps after the last one.
  always_comb begin
    scan_idx_d = scan_idx_q;
    if (adv && is_scan) begin
      scan_idx_d = (scan_idx_q == ScanLast) ? '0 : scan_idx_q + ScanW'(1);
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (adv && is_scan) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      scan_idx_q <= scan_idx_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // The display segments are active low, so the stored pattern is inverted.
  always_ff @(posedge clk_i) begin
    if (adv && is_scan) begin
      seg_q <= ~scan_pat;
      en_q  <= DIGITS'(1) << scan_idx_q;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign segments_n_o   = seg_q;
  assign digit_enable_o = en_q;

  // A presented result always drives exactly one digit.
  `ASSERT_ONEHOT_WHEN(a_enable_onehot, clk_i, rst_ni, out_valid_o, digit_enable_o, "not one-hot")

  // The scan index never leaves the range of fitted digits.
  `ASSERT_PROP(a_scan_range, clk_i, rst_ni, scan_idx_q <= ScanLast, "scan index out of range")

  // A scan tick held back by a full output register stays in the input register.
  `ASSERT_PROP(a_scan_held, clk_i, rst_ni, scan_stall |=> in_vld_q && is_scan, "scan tick lost")

endmodule

FILE: bench/seven_segment_text_display_top_tb.sv
`default_nettype none

// Self-checking bench for the six-digit multiplexed text display.
// Items go in through the valid/ready input channel. Scan results come back
// through the output channel. A behavioural model of the digit buffer, the
// text write position and the scan index lives in this module. Every item
// accepted at the input is applied to that model. Every scan tick pushes the
// segment pattern and enable that the block should produce onto a queue. A
// separate process pops that queue for each result taken at the output and
// compares it field by field.
module seven_segment_text_display_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sstd_pkg::*;

  localparam int unsigned NumDigits  = 6;
  // Quiet cycles allowed before the run is declared hung. This is far above
  // the longest correct gap: the output hold-off plus a few idle bursts.
  localparam int unsigned QuietLimit = 1000;
  localparam int unsigned HoldCycles = 200;
  localparam int unsigned DrainCycles = 6;

  // Seven-segment patterns of the decimal digits, digit 0 in the low byte.
  localparam logic [79:0] DigitGlyphs = {8'h6f, 8'h7f, 8'h07, 8'h7d, 8'h6d,
                                         8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f};

  typedef struct packed {
    logic [7:0]           segments_n;
    logic [NumDigits-1:0] enable;
  } scan_frame_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [1:0]           func_i;
  logic [7:0]           char_code_i;
  logic                 first_i;
  logic [2:0]           position_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [7:0]           segments_n_o;
  logic [NumDigits-1:0] digit_enable_o;

  // Model of the display state, updated as each item is accepted.
  logic [7:0]  shadow_digits [NumDigits];
  int unsigned shadow_wpos;
  int unsigned shadow_scan;

  // Scan results that the block still owes, oldest first.
  scan_frame_t frames_due_q [$];

  int unsigned items_sent;
  int unsigned frames_checked;
  int unsigned mismatch_count;

  // Idle controls. The test tasks change them only just after a rising edge,
  // and the receiver reads them at the falling edge, so there is no race.
  bit          send_idle_on;
  bit          recv_idle_on;
  int unsigned hold_left;

  seven_segment_text_display_top #(
    .DIGITS(NumDigits)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .char_code_i   (char_code_i),
    .first_i       (first_i),
    .position_i    (position_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .segments_n_o  (segments_n_o),
    .digit_enable_o(digit_enable_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Text font: bit 8 says whether the character is known at all.
  function automatic logic [8:0] glyph_for(input logic [7:0] c);
    logic [8:0] g;
    g = {1'b1, 8'h00};
    if (c >= "0" && c <= "9") begin
      g[7:0] = DigitGlyphs[(c - "0") * 8 +: 8];
    end else begin
      case (c)
        "A", "a": g[7:0] = 8'h77;
        "B", "b": g[7:0] = 8'h7c;
        "C", "c": g[7:0] = 8'h39;
        "D", "d": g[7:0] = 8'h5e;
        "E", "e": g[7:0] = 8'h79;
        "F", "f": g[7:0] = 8'h71;
        "O":      g[7:0] = 8'h3f;
        "o":      g[7:0] = 8'h5c;
        "R", "r": g[7:0] = 8'h50;
        "P", "p": g[7:0] = 8'h73;
        "N", "n": g[7:0] = 8'h37;
        "-":      g[7:0] = 8'h40;
        " ", 8'h09: g[7:0] = 8'h00;
        "L":      g[7:0] = 8'h38;
        "l":      g[7:0] = 8'h30;
        "V":      g[7:0] = 8'h3e;
        "H":      g[7:0] = 8'h76;
        default:  g[8] = 1'b0;
      endcase
    end
    return g;
  endfunction

  // Applies one accepted item to the display model. A scan tick also queues
  // the result that the block must return for it.
  task automatic update_display_model(input func_e f, input logic [7:0] c,
                                      input logic restart, input logic [2:0] p);
    logic [8:0]  g;
    scan_frame_t frame;
    case (f)
      FuncText: begin
        if (restart) begin
          shadow_wpos = 0;
        end
        // Once the write position has run off the end, everything up to the
        // next restart is dropped, dots included.
        if (shadow_wpos < NumDigits) begin
          if (c == CharNul) begin
            for (int unsigned k = shadow_wpos; k < NumDigits; k++) begin
              shadow_digits[k] = Blank;
            end
            shadow_wpos = NumDigits;
          end else if (c == CharDot) begin
            // A dot lights the point of the digit before; with no digit
            // before it there is nothing to mark.
            if (shadow_wpos > 0) begin
              shadow_digits[shadow_wpos - 1] |= DotBit;
            end
          end else begin
            g = glyph_for(c);
            if (g[8]) begin
              shadow_digits[shadow_wpos] = g[7:0];
            end
            shadow_wpos++;
          end
        end
      end
      FuncDec: begin
        if (p < NumDigits && c >= "0" && c <= "9") begin
          shadow_digits[p] = DigitGlyphs[(c - "0") * 8 +: 8];
        end
      end
      FuncScan: begin
        if (shadow_scan >= NumDigits) begin
          shadow_scan = 0;
        end
        frame.segments_n = ~shadow_digits[shadow_scan];
        frame.enable     = NumDigits'(1) << shadow_scan;
        frames_due_q.push_back(frame);
        shadow_scan = (shadow_scan + 1) % NumDigits;
      end
      default: begin
        for (int unsigned k = 0; k < NumDigits; k++) begin
          shadow_digits[k] = Blank;
        end
      end
    endcase
  endtask

  // Offers one item and returns just after the edge at which it is taken.
  // Valid stays high on return so that back-to-back items carry no gap.
  task automatic send_item(input func_e f, input logic [7:0] c,
                           input logic restart, input logic [2:0] p);
    int unsigned gap;
    @(negedge clk_i);
    if (send_idle_on && $urandom_range(0, 3) == 0) begin
      gap        = $urandom_range(1, 3);
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    func_i      = f;
    char_code_i = c;
    first_i     = restart;
    position_i  = p;
    do @(posedge clk_i); while (!in_ready_o);
    update_display_model(f, c, restart, p);
    items_sent++;
  endtask

  // Six ticks visit every digit once, wherever the scan happens to stand.
  task automatic scan_all_digits();
    repeat (NumDigits) send_item(FuncScan, 8'($urandom), 1'($urandom), 3'($urandom));
  endtask

  // Mostly characters from the font, then dots, arbitrary bytes and the odd
  // terminator.
  function automatic logic [7:0] pick_text_char();
    string       known;
    int unsigned r;
    known = "0123456789AaBbCcDdEeFfOoRrPpNn- LlVH\t";
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return known[$urandom_range(0, known.len() - 1)];
    end else if (r < 75) begin
      return CharDot;
    end else if (r < 93) begin
      return 8'($urandom);
    end
    return CharNul;
  endfunction

  // One burst of random traffic: usually a whole line of text followed by
  // scans to read it back, sometimes decimal writes, a clear, or noise.
  task automatic send_random_burst();
    int unsigned kind;
    int unsigned len;
    logic [7:0]  c;
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      len = $urandom_range(1, 8);
      for (int unsigned k = 0; k < len; k++) begin
        send_item(FuncText, pick_text_char(),
                  (k == 0) ? 1'b1 : ($urandom_range(0, 15) == 0),
                  3'($urandom));
      end
      repeat ($urandom_range(3, 8)) send_item(FuncScan, 8'($urandom), 1'($urandom),
                                                3'($urandom));
    end else if (kind == 6) begin
      repeat ($urandom_range(1, 3)) begin
        c = ($urandom_range(0, 4) != 0) ? 8'("0" + $urandom_range(0, 9)) : 8'($urandom);
        send_item(FuncDec, c, 1'($urandom), 3'($urandom_range(0, 7)));
      end
      repeat ($urandom_range(1, 6)) send_item(FuncScan, 8'($urandom), 1'($urandom),
                                                3'($urandom));
    end else if (kind == 7) begin
      send_item(FuncClear, 8'($urandom), 1'($urandom), 3'($urandom));
      repeat ($urandom_range(1, 3)) send_item(FuncScan, 8'($urandom), 1'($urandom),
                                                3'($urandom));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        send_item(func_e'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
                  3'($urandom));
      end
    end
  endtask

  // Decimal writes: one in range, one at the highest position code, one with
  // a character that is not a digit. Only the first may change the buffer.
  task automatic test_decimal_write();
    send_item(FuncDec, "9", 1'b0, 3'd5);
    send_item(FuncDec, "3", 1'b0, 3'd7);
    send_item(FuncDec, "x", 1'b0, 3'd0);
  endtask

  // A line of text that runs past the last digit. It opens with a dot at
  // the first position, holds an unknown character and the top byte value,
  // and ends with a character and a dot that must both be dropped.
  task automatic test_text_line();
    send_item(FuncText, CharDot, 1'b1, 3'd0);
    send_item(FuncText, "H",     1'b0, 3'd0);
    send_item(FuncText, CharDot, 1'b0, 3'd0);
    send_item(FuncText, "8",     1'b0, 3'd0);
    send_item(FuncText, "#",     1'b0, 3'd0);
    send_item(FuncText, 8'hff,   1'b0, 3'd7);
    send_item(FuncText, "-",     1'b0, 3'd0);
    send_item(FuncText, "l",     1'b0, 3'd0);
    send_item(FuncText, "A",     1'b0, 3'd0);
    send_item(FuncText, CharDot, 1'b0, 3'd0);
    scan_all_digits();
  endtask

  // The terminator blanks the rest of the line; a clear then blanks it all.
  task automatic test_terminator_and_clear();
    send_item(FuncText, "n",     1'b1, 3'd0);
    send_item(FuncText, CharNul, 1'b0, 3'd0);
    send_item(FuncText, "E",     1'b0, 3'd0);
    send_item(FuncDec,  "7",     1'b0, 3'd2);
    scan_all_digits();
    send_item(FuncClear, 8'h00, 1'b0, 3'd0);
    send_item(FuncScan,  8'h00, 1'b0, 3'd0);
  endtask

  task automatic test_random_traffic(input int unsigned count);
    int unsigned stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      // Idling is switched per burst so that long stretches run without it.
      send_idle_on = ($urandom_range(0, 3) != 0);
      recv_idle_on = ($urandom_range(0, 3) != 0);
      send_random_burst();
    end
  endtask

  // The receiver stops taking results for a long stretch while scan ticks
  // keep coming, so the output register and the input stage both fill and
  // the block has to hold off the sender.
  task automatic test_output_backpressure();
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    send_item(FuncScan, 8'h00, 1'b0, 3'd0);
    hold_left = HoldCycles;
    for (int unsigned k = 0; k < 40; k++) begin
      if (k % 5 == 4) begin
        send_item(FuncText, pick_text_char(), 1'($urandom), 3'($urandom));
      end else begin
        send_item(FuncScan, 8'($urandom), 1'($urandom), 3'($urandom));
      end
    end
  endtask

  // Closing part of the run: no idling on either side.
  task automatic test_streaming_no_idle(input int unsigned count);
    int unsigned stop_at;
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      send_random_burst();
    end
  endtask

  // Receiver. A pending hold-off takes precedence over the short random stalls.
  initial begin
    int unsigned stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ready_i = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else if (recv_idle_on && $urandom_range(0, 4) == 0) begin
        out_ready_i = 1'b0;
        stall_left  = $urandom_range(0, 2);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  // Result checker: every result taken is matched against the oldest frame due.
  always @(posedge clk_i) begin
    scan_frame_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (frames_due_q.size() == 0) begin
        $error("scan result with none due: segments_n %h, digit_enable %b",
               segments_n_o, digit_enable_o);
        mismatch_count++;
      end else begin
        want = frames_due_q.pop_front();
        frames_checked++;
        if (segments_n_o !== want.segments_n) begin
          $error("segments_n: expected %h, actual %h", want.segments_n, segments_n_o);
          mismatch_count++;
        end
        if (digit_enable_o !== want.enable) begin
          $error("digit_enable: expected %b, actual %b", want.enable, digit_enable_o);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $error("no item moved on either channel for %0d cycles", QuietLimit);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    func_i       = FuncText;
    char_code_i  = 8'h00;
    first_i      = 1'b0;
    position_i   = 3'd0;
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    hold_left    = 0;
    items_sent     = 0;
    frames_checked = 0;
    mismatch_count = 0;
    shadow_wpos = 0;
    shadow_scan = 0;
    for (int unsigned k = 0; k < NumDigits; k++) begin
      shadow_digits[k] = Blank;
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_decimal_write();
    test_text_line();
    test_terminator_and_clear();
    test_random_traffic(1100);
    test_output_backpressure();
    test_streaming_no_idle(350);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    // The watchdog bounds this wait if results go missing.
    while (frames_due_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d items of all four kinds (text, decimal, scan, clear), with idle bursts",
             items_sent);
    $display("and a long output hold-off; %0d scan results were compared.", frames_checked);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
